// ===== src/rrts_pkg.sv =====
// Package for the round-robin task scheduler.
// Holds field widths, operation codes, channel item structs and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package rrts_pkg;

  localparam int TASK_W        = 4;
  localparam int FUNC_W        = 3;
  localparam int QLEN_W        = 5;
  localparam int NUM_IDS       = 2 ** TASK_W;
  localparam int DEF_MAX_TASKS = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CREATE   = 3'd0,
    FUNC_BLOCK    = 3'd1,
    FUNC_WAKE     = 3'd2,
    FUNC_SCHEDULE = 3'd3,
    FUNC_START    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    SCAN_MATCH,
    SCAN_ROTATE,
    SCAN_PEEK
  } scan_mode_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TASK_W-1:0] task_id;
  } sched_in_t;

  typedef struct packed {
    logic [TASK_W-1:0] next_task;
    logic              next_valid;
    logic [TASK_W-1:0] current_task;
    logic [QLEN_W-1:0] queue_length;
    logic              was_sleeping;
  } sched_out_t;

  typedef struct packed {
    logic       load;
    logic       block_mark;
    logic       drop_pending;
    logic       scan_start;
    scan_mode_e scan_mode;
    logic       scan_step;
    logic       shrink;
    logic       append;
    logic       clear_sleep;
    logic       result;
  } sched_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              slept;
    logic              empty;
    logic              scan_done;
  } sched_sts_t;

endpackage

`default_nettype wire

// ===== src/round_robin_task_scheduler.sv =====
// Top level of the round-robin task scheduler.
// Joins rrts_ctrl and rrts_dp; types from rrts_pkg.
//
//   channel | handshake                  | item
//   evt     | evt_valid in, evt_stall out | sched_in_t  {func, task_id}
//   rsp     | rsp_valid out, rsp_stall in | sched_out_t {next_task .. was_sleeping}
//
// Accept to result: create and schedule pass scan, shrink and append; block and
// start pass scan and shrink; wake appends only a sleeping task; unused codes and an
// empty queue go to result. The scan reads one run queue entry per cycle.
// Reset: one cycle of rst; queue memory is not cleared, the length covers it.
// rsp_stall holds only the result register: the next item is accepted and
// runs up to its result cycle, where it waits for the register to free.
`default_nettype none

module round_robin_task_scheduler #(
  parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 evt_valid,
  output logic                 evt_stall,
  input  rrts_pkg::sched_in_t  evt,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rrts_pkg::sched_out_t rsp
);
  import rrts_pkg::*;

  sched_cmd_t cmd;
  sched_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

// ===== src/rrts_ctrl.sv =====
// Controller state machine of the task scheduler.
// Sequences load, dispatch, queue scan, shrink, append and result; uses rrts_pkg.
`default_nettype none

module rrts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 evt_valid,
  output logic                 evt_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  rrts_pkg::sched_sts_t sts,
  output rrts_pkg::sched_cmd_t cmd
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHRINK,
    ST_APPEND,
    ST_RESULT
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign evt_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (evt_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.func)
          FUNC_CREATE: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_MATCH;
            state_next     = ST_SCAN;
          end
          FUNC_BLOCK: begin
            cmd.block_mark = 1'b1;
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_MATCH;
            state_next     = ST_SCAN;
          end
          FUNC_WAKE: begin
            state_next = sts.slept ? ST_APPEND : ST_RESULT;
          end
          FUNC_SCHEDULE: begin
            if (sts.empty) begin
              cmd.drop_pending = 1'b1;
              state_next       = ST_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = SCAN_ROTATE;
              state_next     = ST_SCAN;
            end
          end
          FUNC_START: begin
            if (sts.empty) begin
              cmd.drop_pending = 1'b1;
              state_next       = ST_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = SCAN_PEEK;
              state_next     = ST_SCAN;
            end
          end
          default: state_next = ST_RESULT;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_SHRINK;
        end
      end
      ST_SHRINK: begin
        cmd.shrink = 1'b1;
        if (sts.func == FUNC_CREATE || sts.func == FUNC_SCHEDULE) begin
          state_next = ST_APPEND;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_APPEND: begin
        cmd.append      = 1'b1;
        cmd.clear_sleep = (sts.func != FUNC_SCHEDULE);
        state_next      = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.result = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rrts_dp.sv =====
// Datapath of the task scheduler: run queue memory, queue length, sleep flags,
// running/pending task registers and the result register. Uses rrts_pkg.
`default_nettype none

module rrts_dp #(
  parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rrts_pkg::sched_in_t  evt,
  input  rrts_pkg::sched_cmd_t cmd,
  output rrts_pkg::sched_sts_t sts,
  output rrts_pkg::sched_out_t rsp
);
  import rrts_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int LEN_W = $clog2(MAX_TASKS + 1);

  logic [TASK_W-1:0]  run_order [MAX_TASKS];
  logic [LEN_W-1:0]   length;
  logic [LEN_W-1:0]   pos;
  logic [IDX_W-1:0]   rpos;
  logic               rvalid;
  logic               found;
  scan_mode_e         mode;
  logic [NUM_IDS-1:0] sleep_flags;
  logic [TASK_W-1:0]  running;
  logic [TASK_W-1:0]  pending;
  logic               pend_valid;

  logic [FUNC_W-1:0]  func;
  logic [TASK_W-1:0]  tid;
  logic [TASK_W-1:0]  app_task;
  logic               slept;
  logic [TASK_W-1:0]  rdata;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [TASK_W-1:0]  wr_data;
  logic               shift_wr;
  logic               room;
  logic               head;
  logic               data_in;

  assign rd_en    = cmd.scan_step && (pos < length);
  assign rd_addr  = pos[IDX_W-1:0];
  assign data_in  = cmd.scan_step && rvalid;
  assign shift_wr = data_in && found;
  assign room     = (length < LEN_W'(MAX_TASKS));
  assign head     = (rpos == '0);

  // entries behind the removed one move down by one
  always_comb begin
    wr_en = shift_wr || (cmd.append && room);
    if (shift_wr) begin
      wr_addr = rpos - IDX_W'(1);
      wr_data = rdata;
    end else begin
      wr_addr = length[IDX_W-1:0];
      wr_data = app_task;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      run_order[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= run_order[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length      <= '0;
      sleep_flags <= '0;
      running     <= '0;
      pending     <= '0;
      pend_valid  <= 1'b0;
      pos         <= '0;
      rvalid      <= 1'b0;
      found       <= 1'b0;
      mode        <= SCAN_MATCH;
    end else begin
      rvalid <= rd_en;
      if (rd_en) begin
        pos <= pos + LEN_W'(1);
      end
      if (cmd.scan_start) begin
        pos   <= '0;
        found <= 1'b0;
        mode  <= cmd.scan_mode;
      end
      if (cmd.block_mark) begin
        if (pend_valid && pending == tid) begin
          pending <= running;
        end
        sleep_flags[tid] <= 1'b1;
      end
      if (cmd.drop_pending) begin
        pend_valid <= 1'b0;
      end
      if (data_in) begin
        if (mode == SCAN_MATCH && !found && rdata == tid) begin
          found <= 1'b1;
        end
        if (mode != SCAN_MATCH && head) begin
          pending    <= rdata;
          running    <= rdata;
          pend_valid <= 1'b1;
          if (mode == SCAN_ROTATE) begin
            found <= 1'b1;
          end
        end
      end
      if (cmd.shrink && found) begin
        length <= length - LEN_W'(1);
      end
      if (cmd.append && room) begin
        length <= length + LEN_W'(1);
        if (cmd.clear_sleep) begin
          sleep_flags[app_task] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rpos <= rd_addr;
    if (cmd.load) begin
      func     <= evt.func;
      tid      <= evt.task_id;
      app_task <= evt.task_id;
      slept    <= sleep_flags[evt.task_id];
    end
    if (data_in && mode == SCAN_ROTATE && head) begin
      app_task <= rdata;
    end
    if (cmd.result) begin
      rsp.next_task    <= pending;
      rsp.next_valid   <= pend_valid;
      rsp.current_task <= running;
      rsp.queue_length <= QLEN_W'(length);
      rsp.was_sleeping <= slept;
    end
  end

  assign sts.func      = func;
  assign sts.slept     = slept;
  assign sts.empty     = (length == '0);
  assign sts.scan_done = (pos >= length) && !rvalid;

endmodule

`default_nettype wire

// ===== src/rrts_chk.sv =====
// Port-level checker for the task scheduler, bound to the top level.
// Uses rrts_pkg for the item types.
`default_nettype none

module rrts_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 evt_valid,
  input logic                 evt_stall,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input rrts_pkg::sched_out_t rsp
);
  import rrts_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_qlen_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.queue_length <= QLEN_W'(NUM_IDS))
    else $error("queue length beyond task count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_stall |=> evt_stall)
    else $error("item accepted on back-to-back cycles");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind round_robin_task_scheduler rrts_chk u_rrts_chk (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt_valid),
  .evt_stall (evt_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for round_robin_task_scheduler: a directed event table, then
// weighted random events, each result checked against a bench predictor or, for typed rows,
// against the row's expected value. Depends on rrts_pkg and the scheduler RTL.

module tb;
  import rrts_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;
  localparam int RANDOM_EVENTS = 625;
  localparam int LONG_HOLD     = 300;
  localparam sched_out_t IDLE_RESULT = '0;
  localparam sched_out_t ONE_QUEUED  = '{next_task: 4'd0, next_valid: 1'b0,
                                         current_task: 4'd0, queue_length: 5'd1,
                                         was_sleeping: 1'b0};

  typedef struct {
    sched_in_t  ev;
    bit         typed;
    sched_out_t want;
  } event_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       evt_valid = 1'b0;
  logic       evt_stall;
  sched_in_t  evt = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  sched_out_t rsp;

  event_row_t directed_rows[$];
  sched_out_t sched_results_due[$];
  sched_out_t want_r;
  int         errs = 0;
  int         sent = 0;
  bit         quiet = 1'b0;

  // predicted scheduler state
  logic [TASK_W-1:0] run_q [DEF_MAX_TASKS];
  int                run_len;
  logic [NUM_IDS-1:0] asleep;
  logic [TASK_W-1:0] cur_task;
  logic [TASK_W-1:0] nxt_task;
  logic              nxt_ok;

  round_robin_task_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int run_q_find(logic [TASK_W-1:0] t);
    for (int i = 0; i < run_len; i++)
      if (run_q[i] == t) return i;
    return -1;
  endfunction

  function automatic void run_q_drop(int pos);
    for (int i = pos; i + 1 < run_len; i++) run_q[i] = run_q[i + 1];
    run_len--;
  endfunction

  function automatic bit run_q_push(logic [TASK_W-1:0] t);
    if (run_len >= DEF_MAX_TASKS) return 1'b0;
    run_q[run_len] = t;
    run_len++;
    return 1'b1;
  endfunction

  function automatic sched_out_t sched_advance(sched_in_t ev);
    logic [TASK_W-1:0] t;
    logic              slept;
    int                pos;
    sched_out_t        r;
    t = ev.task_id;
    slept = asleep[t];
    case (ev.func)
      FUNC_CREATE: begin
        pos = run_q_find(t);
        if (pos >= 0) begin
          run_q_drop(pos);
          void'(run_q_push(t));
          asleep[t] = 1'b0;
        end else if (run_q_push(t)) begin
          asleep[t] = 1'b0;
        end
      end
      FUNC_BLOCK: begin
        if (nxt_ok && nxt_task == t) nxt_task = cur_task;
        pos = run_q_find(t);
        if (pos >= 0) run_q_drop(pos);
        asleep[t] = 1'b1;
      end
      FUNC_WAKE: begin
        if (slept && run_q_push(t)) asleep[t] = 1'b0;
      end
      FUNC_SCHEDULE, FUNC_START: begin
        if (run_len == 0) begin
          nxt_ok = 1'b0;
        end else begin
          nxt_task = run_q[0];
          nxt_ok = 1'b1;
          if (ev.func == FUNC_SCHEDULE) begin
            run_q_drop(0);
            void'(run_q_push(nxt_task));
          end
          cur_task = nxt_task;
        end
      end
      default: ;
    endcase
    r.next_task    = nxt_task;
    r.next_valid   = nxt_ok;
    r.current_task = cur_task;
    r.queue_length = QLEN_W'(run_len);
    r.was_sleeping = slept;
    return r;
  endfunction

  function automatic event_row_t row(logic [FUNC_W-1:0] f, logic [TASK_W-1:0] id,
                                     bit typed, sched_out_t want);
    event_row_t e;
    e.ev.func    = f;
    e.ev.task_id = id;
    e.typed      = typed;
    e.want       = want;
    return e;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mode 0 mixed, 1 fills the run queue, 2 drains it into the sleep set
  function automatic logic [FUNC_W-1:0] pick_func(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      1: begin
        if (r < 65) return FUNC_CREATE;
        if (r < 80) return FUNC_WAKE;
        if (r < 90) return FUNC_SCHEDULE;
        if (r < 97) return FUNC_START;
        return FUNC_BLOCK;
      end
      2: begin
        if (r < 45) return FUNC_BLOCK;
        if (r < 70) return FUNC_SCHEDULE;
        if (r < 80) return FUNC_START;
        if (r < 92) return FUNC_WAKE;
        if (r < 97) return FUNC_CREATE;
        return FUNC_W'($urandom_range(FUNC_UNUSED_5, FUNC_UNUSED_7));
      end
      default: begin
        if (r < 22) return FUNC_CREATE;
        if (r < 40) return FUNC_BLOCK;
        if (r < 58) return FUNC_WAKE;
        if (r < 78) return FUNC_SCHEDULE;
        if (r < 95) return FUNC_START;
        return FUNC_W'($urandom_range(FUNC_UNUSED_5, FUNC_UNUSED_7));
      end
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(sched_in_t item, bit typed, sched_out_t want);
    int         gap;
    sched_out_t got;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt       <= item;
    evt_valid <= 1'b1;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    got = sched_advance(item);
    sched_results_due.push_back(typed ? want : got);
    sent++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    sched_in_t ev;
    for (int i = 0; i < DEF_MAX_TASKS; i++) run_q[i] = '0;
    run_len  = 0;
    asleep   = '0;
    cur_task = '0;
    nxt_task = '0;
    nxt_ok   = 1'b0;

    // empty queue, unused code and wake of an awake task
    directed_rows.push_back(row(FUNC_SCHEDULE, 4'd0, 1'b1, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_START, 4'd15, 1'b1, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_UNUSED_7, 4'd15, 1'b1, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_WAKE, 4'd5, 1'b1, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_CREATE, 4'd0, 1'b1, ONE_QUEUED));
    directed_rows.push_back(row(FUNC_CREATE, 4'd15, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_CREATE, 4'd7, 1'b0, IDLE_RESULT));
    // create of a queued task moves it to the tail
    directed_rows.push_back(row(FUNC_CREATE, 4'd0, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_START, 4'd3, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_SCHEDULE, 4'd12, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_SCHEDULE, 4'd0, 1'b0, IDLE_RESULT));
    // block of the pending task, of an unqueued task, of a sleeping task
    directed_rows.push_back(row(FUNC_BLOCK, 4'd7, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_BLOCK, 4'd9, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_BLOCK, 4'd9, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_WAKE, 4'd9, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_BLOCK, 4'd15, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_CREATE, 4'd15, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_UNUSED_5, 4'd10, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_BLOCK, 4'd0, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_BLOCK, 4'd15, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_BLOCK, 4'd9, 1'b0, IDLE_RESULT));
    // emptied queue: next_valid drops, tasks hold
    directed_rows.push_back(row(FUNC_SCHEDULE, 4'd6, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_START, 4'd6, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_WAKE, 4'd0, 1'b0, IDLE_RESULT));
    directed_rows.push_back(row(FUNC_SCHEDULE, 4'd0, 1'b0, IDLE_RESULT));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      offer(directed_rows[k].ev, directed_rows[k].typed, directed_rows[k].want);

    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      quiet = (n >= 120 && n < 200) || (n >= 480 && n < 540);
      ev.func = pick_func((n / 60) % 3);
      ev.task_id = TASK_W'($urandom_range(0, NUM_IDS - 1));
      if (ev.func == FUNC_BLOCK && nxt_ok && $urandom_range(0, 99) < 30)
        ev.task_id = nxt_task;
      offer(ev, 1'b0, IDLE_RESULT);
    end
    evt_valid <= 1'b0;

    while (sched_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errs == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin : rsp_side
    int  run;
    bit  held_long;
    held_long = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held_long && sent >= 300) begin
        // long back-pressure: the scheduler must fill up and stall its input
        held_long = 1'b1;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (quiet || $urandom_range(0, 99) < 60) begin
        rsp_stall <= 1'b0;
        @(negedge clk);
      end else begin
        run = idle_len();
        rsp_stall <= 1'b1;
        repeat (run) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (sched_results_due.size() == 0) begin
        $error("unexpected result item: %p", rsp);
        errs++;
      end else begin
        want_r = sched_results_due.pop_front();
        if (rsp.next_task !== want_r.next_task) begin
          $error("next_task: expected %0d, got %0d", want_r.next_task, rsp.next_task);
          errs++;
        end
        if (rsp.next_valid !== want_r.next_valid) begin
          $error("next_valid: expected %0d, got %0d", want_r.next_valid, rsp.next_valid);
          errs++;
        end
        if (rsp.current_task !== want_r.current_task) begin
          $error("current_task: expected %0d, got %0d", want_r.current_task,
                 rsp.current_task);
          errs++;
        end
        if (rsp.queue_length !== want_r.queue_length) begin
          $error("queue_length: expected %0d, got %0d", want_r.queue_length,
                 rsp.queue_length);
          errs++;
        end
        if (rsp.was_sleeping !== want_r.was_sleeping) begin
          $error("was_sleeping: expected %0d, got %0d", want_r.was_sleeping,
                 rsp.was_sleeping);
          errs++;
        end
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== round_robin_task_scheduler.f =====
src/rrts_pkg.sv
src/rrts_ctrl.sv
src/rrts_dp.sv
src/round_robin_task_scheduler.sv
src/rrts_chk.sv
tb/tb.sv
